[hw/rtl/idrba_pkg.sv]
// ----------------------------------------------------------------------------
// idrba_pkg
// Shared types and constants of the ID range block allocator.
// ----------------------------------------------------------------------------
package idrba_pkg;

    localparam int DEF_NUM_REQUESTERS = 8;
    localparam int DEF_REUSE_DEPTH    = 8;
    localparam int DEF_ID_BITS        = 24;

    localparam int CMD_W   = 2;
    localparam int REQ_W   = 3;
    localparam int START_W = 24;
    localparam int COUNT_W = 11;
    localparam int TOTAL_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [TOTAL_W-1:0] TOTAL_IDS_RESET  = TOTAL_W'(1024);
    localparam logic [COUNT_W-1:0] BLOCK_SIZE_RESET = COUNT_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_IDS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_DIED    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic push;
    } stack_op_t;

endpackage

[hw/rtl/idrba_stack.sv]
// ----------------------------------------------------------------------------
// idrba_stack
// LIFO store of recycled ID ranges in a synchronous memory with its depth.
// ----------------------------------------------------------------------------
module idrba_stack #(
    parameter int REUSE_DEPTH = idrba_pkg::DEF_REUSE_DEPTH,
    parameter int ID_BITS     = idrba_pkg::DEF_ID_BITS,
    localparam int DEPTH_W    = $clog2(REUSE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  idrba_pkg::stack_op_t          op,
    input  logic [ID_BITS-1:0]            push_start,
    input  logic [idrba_pkg::COUNT_W-1:0] push_count,
    output logic [DEPTH_W-1:0]            depth,
    output logic [ID_BITS-1:0]            top_start,
    output logic [idrba_pkg::COUNT_W-1:0] top_count
);
    import idrba_pkg::*;

    localparam int ADDR_W = (REUSE_DEPTH > 1) ? $clog2(REUSE_DEPTH) : 1;

    logic [ID_BITS-1:0] start_mem [REUSE_DEPTH];
    logic [COUNT_W-1:0] count_mem [REUSE_DEPTH];

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] depth_dec;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ID_BITS-1:0] top_start_reg;
    logic [COUNT_W-1:0] top_count_reg;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign wr_addr   = op.pop ? ADDR_W'(depth_dec) : ADDR_W'(depth_reg);

    always_comb
    begin
        depth_next = depth_reg;
        if (op.pop && !op.push)
        begin
            depth_next = depth_dec;
        end
        else if (op.push && !op.pop)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            start_mem[wr_addr] <= push_start;
            count_mem[wr_addr] <= push_count;
        end
        if (rd_en)
        begin
            top_start_reg <= start_mem[ADDR_W'(depth_dec)];
            top_count_reg <= count_mem[ADDR_W'(depth_dec)];
        end
    end

    assign depth     = depth_reg;
    assign top_start = top_start_reg;
    assign top_count = top_count_reg;

endmodule

[hw/rtl/id_range_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// id_range_block_allocator_top
// Grants blocks of consecutive IDs, recycling ranges of dead requesters.
// ----------------------------------------------------------------------------
// A command is accepted in S_IDLE, where the recycle stack and holder table
// memories are read; in S_EXEC the entry is updated and written back. The
// result word is registered onto the outputs with done high for one cycle; a
// new command may start in that same cycle. The receiver cannot stall; every
// command, including a release, yields exactly one word.
module id_range_block_allocator_top #(
    parameter int NUM_REQUESTERS = idrba_pkg::DEF_NUM_REQUESTERS,
    parameter int REUSE_DEPTH    = idrba_pkg::DEF_REUSE_DEPTH,
    parameter int ID_BITS        = idrba_pkg::DEF_ID_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [idrba_pkg::CMD_W-1:0]      command,
    input  logic [idrba_pkg::REQ_W-1:0]      requester,
    input  logic                             wr_en,
    input  logic [idrba_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [idrba_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                             done,
    output logic                             granted,
    output logic [idrba_pkg::START_W-1:0]    block_start,
    output logic [idrba_pkg::COUNT_W-1:0]    block_count,
    output logic                             recycled,
    output logic                             dropped
);
    import idrba_pkg::*;

    localparam int DEPTH_W  = $clog2(REUSE_DEPTH + 1);
    localparam int HOLD_AW  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int CMP_W    = (ID_BITS > TOTAL_W) ? ID_BITS : TOTAL_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic                accept;

    logic [TOTAL_W-1:0]  total_ids_reg;
    logic [COUNT_W-1:0]  block_size_reg;
    logic [ID_BITS-1:0]  next_fresh_reg;
    logic [ID_BITS-1:0]  next_fresh_next;
    logic [ID_BITS-1:0]  net_taken_reg;
    logic [ID_BITS-1:0]  net_taken_next;

    cmd_t                cmd_reg;
    logic [HOLD_AW-1:0]  who_reg;
    logic                in_range_reg;

    logic [ID_BITS-1:0]  hold_start_mem [NUM_REQUESTERS];
    logic [COUNT_W-1:0]  hold_count_mem [NUM_REQUESTERS];
    logic [ID_BITS-1:0]  hold_start_reg;
    logic [COUNT_W-1:0]  hold_count_reg;
    logic [NUM_REQUESTERS-1:0] hold_valid_reg;

    logic                hold_we;
    logic                hold_clear;
    logic [ID_BITS-1:0]  hold_wr_start;
    logic [COUNT_W-1:0]  hold_wr_count;

    stack_op_t           stk_op;
    logic [ID_BITS-1:0]  push_start;
    logic [COUNT_W-1:0]  push_count;
    logic [DEPTH_W-1:0]  depth;
    logic [ID_BITS-1:0]  top_start;
    logic [COUNT_W-1:0]  top_count;

    logic [COUNT_W-1:0]  bs;
    logic [CMP_W-1:0]    net_ext;
    logic [CMP_W-1:0]    tot_ext;
    logic [CMP_W-1:0]    rem;
    logic [ID_BITS-1:0]  g_start;
    logic [COUNT_W-1:0]  g_count;
    logic                rec;
    logic                drop;

    logic                done_reg;
    logic                granted_reg;
    logic [START_W-1:0]  block_start_reg;
    logic [COUNT_W-1:0]  block_count_reg;
    logic                recycled_reg;
    logic                dropped_reg;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    idrba_stack #(
        .REUSE_DEPTH (REUSE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .op         (stk_op),
        .push_start (push_start),
        .push_count (push_count),
        .depth      (depth),
        .top_start  (top_start),
        .top_count  (top_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_ids_reg  <= TOTAL_IDS_RESET;
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TOTAL_IDS:  total_ids_reg  <= TOTAL_W'(wr_data);
                REG_BLOCK_SIZE: block_size_reg <= COUNT_W'(wr_data);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(command);
            who_reg      <= HOLD_AW'(requester);
            in_range_reg <= (32'(requester) < NUM_REQUESTERS);
            if (32'(requester) < NUM_REQUESTERS)
            begin
                hold_start_reg <= hold_start_mem[HOLD_AW'(requester)];
                hold_count_reg <= hold_count_mem[HOLD_AW'(requester)];
            end
        end
        if (hold_we)
        begin
            hold_start_mem[who_reg] <= hold_wr_start;
            hold_count_mem[who_reg] <= hold_wr_count;
        end
    end

    assign bs      = (block_size_reg == '0) ? COUNT_W'(1) : block_size_reg;
    assign net_ext = CMP_W'(net_taken_reg);
    assign tot_ext = CMP_W'(total_ids_reg);
    assign rem     = tot_ext - net_ext;

    always_comb
    begin
        stk_op          = '0;
        push_start      = top_start + ID_BITS'(bs);
        push_count      = top_count - bs;
        g_start         = '0;
        g_count         = '0;
        rec             = 1'b0;
        drop            = 1'b0;
        next_fresh_next = next_fresh_reg;
        net_taken_next  = net_taken_reg;
        hold_we         = 1'b0;
        hold_clear      = 1'b0;
        hold_wr_start   = '0;
        hold_wr_count   = '0;
        if (state_reg == S_EXEC && in_range_reg)
        begin
            unique case (cmd_reg)
                CMD_REQUEST:
                begin
                    stk_op.pop = (depth != '0);
                    if (depth != '0 && top_count != '0)
                    begin
                        g_start = top_start;
                        if (top_count > bs)
                        begin
                            g_count     = bs;
                            stk_op.push = 1'b1;
                        end
                        else
                        begin
                            g_count = top_count;
                        end
                        net_taken_next = net_taken_reg + ID_BITS'(g_count);
                    end
                    else if (net_ext < tot_ext)
                    begin
                        g_start         = next_fresh_reg;
                        g_count         = (rem < CMP_W'(bs)) ? COUNT_W'(rem) : bs;
                        next_fresh_next = next_fresh_reg + ID_BITS'(g_count);
                        net_taken_next  = net_taken_reg + ID_BITS'(g_count);
                    end
                    hold_we       = (g_count != '0);
                    hold_clear    = (g_count == '0);
                    hold_wr_start = g_start;
                    hold_wr_count = g_count;
                end
                CMD_FINISH:
                begin
                    hold_clear = 1'b1;
                end
                CMD_DIED:
                begin
                    if (hold_valid_reg[who_reg])
                    begin
                        if (32'(depth) < REUSE_DEPTH)
                        begin
                            stk_op.push    = 1'b1;
                            push_start     = hold_start_reg;
                            push_count     = hold_count_reg;
                            net_taken_next = net_taken_reg - ID_BITS'(hold_count_reg);
                            rec            = 1'b1;
                        end
                        else
                        begin
                            drop = 1'b1;
                        end
                        hold_clear = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_fresh_reg <= ID_BITS'(1);
            net_taken_reg  <= '0;
            hold_valid_reg <= '0;
        end
        else
        begin
            next_fresh_reg <= next_fresh_next;
            net_taken_reg  <= net_taken_next;
            if (hold_we)
            begin
                hold_valid_reg[who_reg] <= 1'b1;
            end
            else if (hold_clear)
            begin
                hold_valid_reg[who_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            granted_reg     <= 1'b0;
            block_start_reg <= '0;
            block_count_reg <= '0;
            recycled_reg    <= 1'b0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg       <= S_IDLE;
                    done_reg        <= 1'b1;
                    granted_reg     <= (g_count != '0);
                    block_start_reg <= (g_count != '0) ? START_W'(g_start) : '0;
                    block_count_reg <= g_count;
                    recycled_reg    <= rec;
                    dropped_reg     <= drop;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign block_start = block_start_reg;
    assign block_count = block_count_reg;
    assign recycled    = recycled_reg;
    assign dropped     = dropped_reg;

endmodule
